>>> rtl/rmls_pkg.sv
package rmls_pkg;

  // Region geometry
  localparam int REGION_ADDR_BITS = 12;
  localparam int REGION_BYTES     = 1 << REGION_ADDR_BITS;
  localparam int REGION_COUNT     = 3;
  localparam int MEM_DEPTH        = REGION_COUNT * REGION_BYTES;
  localparam int MEM_AW           = REGION_ADDR_BITS + 2;

  // Region select codes, address bits 31..20
  localparam logic [11:0] SEL_PROGRAM = 12'h004;
  localparam logic [11:0] SEL_DATA    = 12'h100;
  localparam logic [11:0] SEL_STACK   = 12'h7FF;

  // Access command
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_REGION = 2'd1,
    ST_BAD_SIZE  = 2'd2
  } status_t;

  // Bank index inside the shared byte memory
  typedef enum logic [1:0] {
    RG_PROGRAM = 2'd0,
    RG_DATA    = 2'd1,
    RG_STACK   = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_DRAIN,
    S_FIN
  } state_t;

endpackage

>>> rtl/rmls_if.sv
interface rmls_req_if;
  import rmls_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [31:0]        address;
  logic [1:0]         size;
  logic signed [31:0] write_data;

  modport source (output valid, output command, output address, output size,
                  output write_data, input ready);
  modport sink   (input valid, input command, input address, input size,
                  input write_data, output ready);
endinterface

interface rmls_rsp_if;
  import rmls_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_data;
  status_t            status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink   (input valid, input read_data, input status, output ready);
endinterface

>>> rtl/region_mapped_load_store_memory.sv
// Channel  Dir  Fields                                  Accepted when
// req      in   command, address, size, write_data      req.valid && req.ready
// rsp      out  read_data, status                       rsp.valid && rsp.ready
//
// One byte-wide memory holds all three regions; a small sequencer moves one
// byte per cycle through its single port: n = 1, 2 or 4 bytes in S_BUSY,
// then S_DRAIN for a read, then S_FIN; an error item goes straight to S_FIN.
// The result sits in an output register, so a new item is taken while it
// waits. rst is synchronous; memory contents are not cleared.
module region_mapped_load_store_memory (
  input  logic            clk,
  input  logic            rst,
  rmls_req_if.sink        req,
  rmls_rsp_if.source      rsp
);
  import rmls_pkg::*;

  state_t                      state, state_next;
  logic                        item_cmd;
  region_t                     item_region;
  logic [REGION_ADDR_BITS-1:0] item_offset;
  logic [1:0]                  item_size;
  status_t                     item_status;
  logic [31:0]                 wr_shift;
  logic [1:0]                  byte_cnt;
  logic [1:0]                  cnt_last;
  logic [31:0]                 rd_acc;
  logic                        rd_pend;
  logic                        out_valid;
  logic signed [31:0]          out_data;
  status_t                     out_status;

  logic                        accept;
  logic                        done_load;
  logic                        region_ok;
  region_t                     region_dec;
  status_t                     status_dec;
  logic [31:0]                 wr_init;
  logic signed [31:0]          result;

  logic                        ram_en;
  logic                        ram_we;
  logic [MEM_AW-1:0]           ram_addr;
  logic [7:0]                  ram_rdata;

  // Region decode of the incoming address
  always_comb begin
    region_ok  = 1'b1;
    region_dec = RG_PROGRAM;
    unique case (req.address[31:20])
      SEL_PROGRAM: region_dec = RG_PROGRAM;
      SEL_DATA:    region_dec = RG_DATA;
      SEL_STACK:   region_dec = RG_STACK;
      default:     region_ok  = 1'b0;
    endcase
  end

  // Status of the incoming item; region check first
  always_comb begin
    if (!region_ok) begin
      status_dec = ST_NO_REGION;
    end else if (req.size == SZ_BAD) begin
      status_dec = ST_BAD_SIZE;
    end else begin
      status_dec = ST_OK;
    end
  end

  // Align the stored bytes so the most significant one sits on top
  always_comb begin
    case (req.size)
      SZ_BYTE: wr_init = {req.write_data[7:0], 24'd0};
      SZ_HALF: wr_init = {req.write_data[15:0], 16'd0};
      default: wr_init = req.write_data;
    endcase
  end

  // Last byte index: 0, 1 or 3
  assign cnt_last = {item_size[1], item_size[1] | item_size[0]};

  // Sign extension of the assembled read value; zero for a write or an error item
  always_comb begin
    if (item_status != ST_OK || item_cmd == CMD_WRITE) begin
      result = '0;
    end else begin
      case (item_size)
        SZ_BYTE: result = {{24{rd_acc[7]}}, rd_acc[7:0]};
        SZ_HALF: result = {{16{rd_acc[15]}}, rd_acc[15:0]};
        default: result = rd_acc;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);
  assign done_load = (state == S_FIN) && (!out_valid || rsp.ready);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (status_dec == ST_OK) ? S_BUSY : S_FIN;
        end
      end
      S_BUSY: begin
        if (byte_cnt == cnt_last) begin
          state_next = (item_cmd == CMD_WRITE) ? S_FIN : S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_FIN;
      S_FIN: begin
        if (done_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers and byte stepping
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd    <= req.command;
      item_region <= region_dec;
      item_offset <= req.address[REGION_ADDR_BITS-1:0];
      item_size   <= req.size;
      item_status <= status_dec;
      wr_shift    <= wr_init;
      byte_cnt    <= '0;
      rd_acc      <= '0;
    end else begin
      if (state == S_BUSY) begin
        item_offset <= item_offset + 1'b1;
        byte_cnt    <= byte_cnt + 1'b1;
        wr_shift    <= {wr_shift[23:0], 8'd0};
      end
      if (rd_pend) begin
        rd_acc <= {rd_acc[23:0], ram_rdata};
      end
    end
  end

  // Read data from the registered RAM returns in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_BUSY) && (item_cmd == CMD_READ);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_data   <= result;
      out_status <= item_status;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign rsp.status    = out_status;

  // Shared byte memory
  assign ram_en   = (state == S_BUSY);
  assign ram_we   = (state == S_BUSY) && (item_cmd == CMD_WRITE);
  assign ram_addr = {item_region, item_offset};

  rmls_ram #(
    .DW    (8),
    .AW    (MEM_AW),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_shift[31:24]),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/rmls_ram.sv
module rmls_ram #(
  parameter int DW    = 8,
  parameter int AW    = 14,
  parameter int DEPTH = 12288
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule
